// ===== rtl/mmt_pkg.sv =====
// mmt_pkg: shared widths, register indexes and operand types for the tile multiplier
// no dependencies
package mmt_pkg;

  // operand and accumulator formats
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 40;

  // configuration register widths
  localparam int ROW_REG_W   = 3;
  localparam int DEPTH_REG_W = 9;
  localparam int COL_REG_W   = 5;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // result index widths
  localparam int OUT_ROW_W = 2;
  localparam int OUT_COL_W = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_DEPTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT   = 2'd2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

// ===== rtl/mmt_ram.sv =====
// mmt_ram: generic single-write, single-read memory with registered read data
// no dependencies
module mmt_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/mmt_mac.sv =====
// mmt_mac: shared multiply-accumulate unit, one row product per cycle, two stages
// depends on mmt_pkg
module mmt_mac
  import mmt_pkg::*;
#(
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ADDR_W-1:0] in_addr,
  input  elem_t             a_op,
  input  elem_t             b_op,
  input  acc_t              acc_in,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output acc_t              wr_data,
  output logic              pending
);

  logic              v1;
  logic              v2;
  logic [ADDR_W-1:0] addr1;
  logic [ADDR_W-1:0] addr2;
  prod_t             prod;
  acc_t              acc_r;

  // tag stage lines up with the memory read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // multiply stage, the A operand and the accumulator come straight from the memories
  always_ff @(posedge clk) begin
    addr1 <= in_addr;
    addr2 <= addr1;
    if (v1) begin
      prod  <= a_op * b_op;
      acc_r <= acc_in;
    end
  end

  // accumulate and write back
  assign wr_en   = v2;
  assign wr_addr = addr2;
  assign wr_data = acc_r + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign pending = v1 | v2;

endmodule

// ===== rtl/matrix_multiply_tile.sv =====
// matrix_multiply_tile: top level, job sequencer, configuration and accumulator store
// depends on mmt_pkg, mmt_ram, mmt_mac
//
//   channel   signals                                          request taken when
//   input     start, busy, element                             start && !busy
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data        cfg_valid && cfg_ready
//   result    strobe, out_row, out_col, product_value, last    strobe (one cycle each)
//
// an A element is written straight into memory with busy staying low; a B element is
// swept by the single shared multiplier, one row per cycle, then its two-stage drain
// after the last B element, row_count * col_count results follow on consecutive
// cycles once the last write-back is done; busy is high meanwhile
// cfg_ready is low while busy or while start is high, so a write never meets an element
// rst is synchronous; registers return to their maximum sizes and the job restarts
// results cannot be stalled: each one is shown for exactly one cycle
module matrix_multiply_tile
  import mmt_pkg::*;
#(
  parameter int MAX_ROWS  = 4,
  parameter int MAX_COLS  = 16,
  parameter int MAX_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [ELEM_W-1:0] element,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   strobe,
  output logic [OUT_ROW_W-1:0]   out_row,
  output logic [OUT_COL_W-1:0]   out_col,
  output logic signed [ACC_W-1:0] product_value,
  output logic                   last
);

  localparam int LEFT_DEPTH = MAX_ROWS * MAX_DEPTH;
  localparam int ACC_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int LEFT_AW    = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
  localparam int ACC_AW     = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

  // largest value each register can hold within its width
  localparam int ROW_LIMIT   = (MAX_ROWS < (1 << ROW_REG_W)) ? MAX_ROWS : (1 << ROW_REG_W) - 1;
  localparam int DEPTH_LIMIT =
    (MAX_DEPTH < (1 << DEPTH_REG_W)) ? MAX_DEPTH : (1 << DEPTH_REG_W) - 1;
  localparam int COL_LIMIT   = (MAX_COLS < (1 << COL_REG_W)) ? MAX_COLS : (1 << COL_REG_W) - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state;
  logic [ROW_REG_W-1:0]   row_count;
  logic [DEPTH_REG_W-1:0] inner_depth;
  logic [COL_REG_W-1:0]   col_count;

  logic                   phase_b;
  logic [ROW_REG_W-1:0]   am;
  logic [DEPTH_REG_W-1:0] ak;
  logic [DEPTH_REG_W-1:0] bk;
  logic [COL_REG_W-1:0]   bn;
  logic [ROW_REG_W-1:0]   rc;
  logic [COL_REG_W-1:0]   ec;
  logic                   issue_done;
  logic                   last_job;
  elem_t                  b_reg;

  logic                   e1;
  logic [OUT_ROW_W-1:0]   row_r;
  logic [OUT_COL_W-1:0]   col_r;
  logic                   last_r;

  logic [ACC_DEPTH-1:0]   acc_valid;
  logic                   acc_vq;

  logic                   accept;
  logic                   cfg_write;
  logic                   issuing;
  logic                   row_end;
  logic                   col_end;
  logic [ROW_REG_W-1:0]   row_v;
  logic [DEPTH_REG_W-1:0] depth_v;
  logic [COL_REG_W-1:0]   col_v;
  logic [ROW_REG_W-1:0]   row_new;
  logic [DEPTH_REG_W-1:0] depth_new;
  logic [COL_REG_W-1:0]   col_new;

  logic                   left_wr_en;
  logic [LEFT_AW-1:0]     left_wr_addr;
  logic [LEFT_AW-1:0]     left_rd_addr;
  logic [ELEM_W-1:0]      left_rd_data;
  logic [ACC_AW-1:0]      acc_rd_addr;
  logic [ACC_W-1:0]       acc_rd_data;
  acc_t                   acc_value;
  logic                   acc_wr_en;
  logic [ACC_AW-1:0]      acc_wr_addr;
  acc_t                   acc_wr_data;
  logic                   mac_pending;

  // handshakes, an element request takes priority over a register write
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !start;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign issuing   = (state == ST_MAC) && !issue_done;

  // end-of-row and end-of-column flags for the row counter, shared by both sweeps, and the emit column counter
  assign row_end = (rc + ROW_REG_W'(1)) == row_count;
  assign col_end = (ec + COL_REG_W'(1)) == col_count;

  // register value saturation; a zero value is raised to one
  always_comb begin
    row_v   = cfg_data[ROW_REG_W-1:0];
    depth_v = cfg_data[DEPTH_REG_W-1:0];
    col_v   = cfg_data[COL_REG_W-1:0];
    if (row_v == '0) begin
      row_new = ROW_REG_W'(1);
    end else if (int'(row_v) > ROW_LIMIT) begin
      row_new = ROW_REG_W'(ROW_LIMIT);
    end else begin
      row_new = row_v;
    end
    if (depth_v == '0) begin
      depth_new = DEPTH_REG_W'(1);
    end else if (int'(depth_v) > DEPTH_LIMIT) begin
      depth_new = DEPTH_REG_W'(DEPTH_LIMIT);
    end else begin
      depth_new = depth_v;
    end
    if (col_v == '0) begin
      col_new = COL_REG_W'(1);
    end else if (int'(col_v) > COL_LIMIT) begin
      col_new = COL_REG_W'(COL_LIMIT);
    end else begin
      col_new = col_v;
    end
  end

  // memory addressing
  assign left_wr_en   = accept && !phase_b;
  assign left_wr_addr = LEFT_AW'(int'(am) * MAX_DEPTH + int'(ak));
  assign left_rd_addr = LEFT_AW'(int'(rc) * MAX_DEPTH + int'(bk));
  assign acc_rd_addr  = LEFT_AW > 0 ?
    ACC_AW'(int'(rc) * MAX_COLS + int'((state == ST_EMIT) ? ec : bn)) : '0;

  // never-written accumulators read as zero
  assign acc_value = acc_vq ? acc_t'(acc_rd_data) : '0;

  always_ff @(posedge clk) begin
    acc_vq <= acc_valid[acc_rd_addr];
  end

  mmt_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (LEFT_DEPTH),
    .ADDR_W(LEFT_AW)
  ) u_left_ram (
    .clk    (clk),
    .wr_en  (left_wr_en),
    .wr_addr(left_wr_addr),
    .wr_data(element),
    .rd_addr(left_rd_addr),
    .rd_data(left_rd_data)
  );

  mmt_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ACC_DEPTH),
    .ADDR_W(ACC_AW)
  ) u_acc_ram (
    .clk    (clk),
    .wr_en  (acc_wr_en),
    .wr_addr(acc_wr_addr),
    .wr_data(acc_wr_data),
    .rd_addr(acc_rd_addr),
    .rd_data(acc_rd_data)
  );

  mmt_mac #(
    .ADDR_W(ACC_AW)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .in_valid(issuing),
    .in_addr (acc_rd_addr),
    .a_op    (elem_t'(left_rd_data)),
    .b_op    (b_reg),
    .acc_in  (acc_value),
    .wr_en   (acc_wr_en),
    .wr_addr (acc_wr_addr),
    .wr_data (acc_wr_data),
    .pending (mac_pending)
  );

  // element payload register
  always_ff @(posedge clk) begin
    if (accept && phase_b) begin
      b_reg <= element;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    row_r <= rc[OUT_ROW_W-1:0];
    col_r <= ec[OUT_COL_W-1:0];
  end

  // job sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      row_count   <= ROW_REG_W'(ROW_LIMIT);
      inner_depth <= DEPTH_REG_W'(DEPTH_LIMIT);
      col_count   <= COL_REG_W'(COL_LIMIT);
      phase_b     <= 1'b0;
      am          <= '0;
      ak          <= '0;
      bk          <= '0;
      bn          <= '0;
      rc          <= '0;
      ec          <= '0;
      issue_done  <= 1'b0;
      last_job    <= 1'b0;
      e1          <= 1'b0;
      last_r      <= 1'b0;
      acc_valid   <= '0;
    end else begin
      e1     <= 1'b0;
      last_r <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && !phase_b) begin
            // load A row-major
            if ((ak + DEPTH_REG_W'(1)) == inner_depth) begin
              ak <= '0;
              if ((am + ROW_REG_W'(1)) == row_count) begin
                am      <= '0;
                phase_b <= 1'b1;
              end else begin
                am <= am + ROW_REG_W'(1);
              end
            end else begin
              ak <= ak + DEPTH_REG_W'(1);
            end
          end else if (accept) begin
            // B element: sweep the active rows
            rc         <= '0;
            issue_done <= 1'b0;
            last_job   <= ((bn + COL_REG_W'(1)) == col_count) &&
                          ((bk + DEPTH_REG_W'(1)) == inner_depth);
            state      <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (!issue_done) begin
            if (row_end) begin
              issue_done <= 1'b1;
            end else begin
              rc <= rc + ROW_REG_W'(1);
            end
          end else if (!mac_pending) begin
            issue_done <= 1'b0;
            rc         <= '0;
            if (last_job) begin
              ec      <= '0;
              phase_b <= 1'b0;
              am      <= '0;
              ak      <= '0;
              bk      <= '0;
              bn      <= '0;
              state   <= ST_EMIT;
            end else begin
              if ((bn + COL_REG_W'(1)) == col_count) begin
                bn <= '0;
                bk <= bk + DEPTH_REG_W'(1);
              end else begin
                bn <= bn + COL_REG_W'(1);
              end
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (!issue_done) begin
            e1     <= 1'b1;
            last_r <= row_end && col_end;
            if (col_end) begin
              ec <= '0;
              if (row_end) begin
                issue_done <= 1'b1;
              end else begin
                rc <= rc + ROW_REG_W'(1);
              end
            end else begin
              ec <= ec + COL_REG_W'(1);
            end
          end else if (!e1) begin
            issue_done <= 1'b0;
            rc         <= '0;
            ec         <= '0;
            acc_valid  <= '0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // accumulator written back
      if (acc_wr_en) begin
        acc_valid[acc_wr_addr] <= 1'b1;
      end

      // register write restarts the job
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ROW_COUNT: begin
            row_count <= row_new;
          end
          REG_INNER_DEPTH: begin
            inner_depth <= depth_new;
          end
          REG_COL_COUNT: begin
            col_count <= col_new;
          end
          default: begin
          end
        endcase
        if (cfg_index == REG_ROW_COUNT || cfg_index == REG_INNER_DEPTH ||
            cfg_index == REG_COL_COUNT) begin
          phase_b   <= 1'b0;
          am        <= '0;
          ak        <= '0;
          bk        <= '0;
          bn        <= '0;
          acc_valid <= '0;
        end
      end
    end
  end

  // result ports
  assign strobe        = e1;
  assign out_row       = row_r;
  assign out_col       = col_r;
  assign product_value = acc_value;
  assign last          = last_r;

  // results only leave while the emit sweep runs
  a_strobe_in_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (state == ST_EMIT))
    else $error("result strobe outside emit sweep");

  // accumulator write-back only during a multiply sweep
  a_wr_in_mac: assert property (@(posedge clk) disable iff (rst)
    acc_wr_en |-> (state == ST_MAC))
    else $error("accumulator write outside multiply sweep");

  // final flag rides on a result
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe)
    else $error("last flag without a result");

  // busy rises only after an accepted B element
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a request");

  // emit sweep follows a drained multiply pipeline
  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !mac_pending)
    else $error("emit started with accumulations in flight");

endmodule
